FILE: rtl/core/tcw_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package tcw_pkg;

  // fixed field widths
  localparam int FLD_W  = 11;
  localparam int BYTE_W = 8;
  localparam int CELL_W = 2 * BYTE_W;

  // character codes and reset attribute
  localparam logic [BYTE_W-1:0] NEWLINE_CHAR = 8'd10;
  localparam logic [BYTE_W-1:0] SPACE_CHAR   = 8'd32;
  localparam logic [BYTE_W-1:0] RESET_ATTR   = 8'h0F;

  // command codes
  typedef enum logic [1:0] {
    OP_PUT   = 2'd0,
    OP_CLEAR = 2'd1,
    OP_READ  = 2'd2,
    OP_SET   = 2'd3
  } op_t;

  // sequencer states
  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_FILL = 6'b000010,
    S_COPY = 6'b000100,
    S_PUTW = 6'b001000,
    S_DIV  = 6'b010000,
    S_FIN  = 6'b100000
  } state_t;

endpackage

`default_nettype wire

FILE: rtl/core/tcw_if.sv
`timescale 1ns / 1ps
`default_nettype none

// command channel
interface tcw_in_if;
  logic                            valid;
  logic                            ready;
  tcw_pkg::op_t                    op;
  logic [tcw_pkg::BYTE_W-1:0]      ch;
  logic [tcw_pkg::BYTE_W-1:0]      attr;
  logic [tcw_pkg::FLD_W-1:0]       cell_index;
  logic [tcw_pkg::FLD_W-1:0]       cursor_load;

  modport source (output valid, op, ch, attr, cell_index, cursor_load, input ready);
  modport sink   (input valid, op, ch, attr, cell_index, cursor_load, output ready);
endinterface

// result channel
interface tcw_out_if;
  logic                            valid;
  logic                            ready;
  logic [tcw_pkg::FLD_W-1:0]       cursor_cell;
  logic [tcw_pkg::BYTE_W-1:0]      read_char;
  logic [tcw_pkg::BYTE_W-1:0]      read_attr;

  modport source (output valid, cursor_cell, read_char, read_attr, input ready);
  modport sink   (input valid, cursor_cell, read_char, read_attr, output ready);
endinterface

`default_nettype wire

FILE: rtl/core/tcw_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module tcw_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2000
) (
  input  wire logic                                  clk,
  input  wire logic                                  we,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                      wdata,
  input  wire logic                                  re,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // one write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

FILE: rtl/core/text_console_writer_core.sv
`timescale 1ns / 1ps
`default_nettype none

// put, newline and read pass through the finish state into the output register; set cursor
// first finds the column of the loaded cursor by a reciprocal multiply in the divide state
// one command at a time: a new command is taken only in the idle state
// clear blanks every cell; a put past the bottom first copies rows up and blanks the last row
// reset: synchronous; a clearing pass over all COLS*ROWS cells (2000 by default) fills the ram
// with space and attribute 0x0F while in_if.ready stays low

module text_console_writer_core #(
  parameter int COLS = 80,
  parameter int ROWS = 25
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  tcw_in_if.sink                          in_if,
  tcw_out_if.source                       out_if,
  input  wire logic                       cfg_we,
  input  wire logic [tcw_pkg::BYTE_W-1:0] cfg_wdata
);

  localparam int CELLS = COLS * ROWS;
  localparam int AW    = $clog2(CELLS);
  localparam int CW    = $clog2(CELLS + 1);
  localparam int CW1   = CW + 1;
  localparam int CLW   = $clog2(COLS);
  localparam int XW    = (CW > tcw_pkg::FLD_W) ? CW : tcw_pkg::FLD_W;
  localparam int DIV_S = CW + CLW;
  localparam int RW    = CW + 2;
  localparam int PW    = DIV_S + CW;

  localparam logic [CW-1:0]  CELLS_C     = CW'(CELLS);
  localparam logic [CW-1:0]  COLS_C      = CW'(COLS);
  localparam logic [CW-1:0]  LAST_ROW_C  = CW'(CELLS - COLS);
  localparam logic [CW-1:0]  LAST_CELL_C = CW'(CELLS - 1);
  localparam logic [CLW-1:0] LAST_COL_C  = CLW'(COLS - 1);
  localparam logic [CW1-1:0] CELLS_W     = CW1'(CELLS);
  localparam logic [CW1-1:0] COLS_W      = CW1'(COLS);
  localparam logic [XW-1:0]  CELLS_X     = XW'(CELLS);
  localparam logic [RW-1:0]  RECIP_C     = RW'((2**DIV_S + COLS - 1) / COLS);

  tcw_pkg::state_t state_r, state_nxt;

  logic [CW-1:0]  cur_r, cur_nxt;
  logic [CLW-1:0] col_r, col_nxt;
  logic [CW-1:0]  ptr_r, ptr_nxt;
  logic [tcw_pkg::BYTE_W-1:0] blank_attr_r;
  logic [tcw_pkg::BYTE_W-1:0] fill_attr_r, fill_attr_nxt;
  logic fill_scroll_r, fill_scroll_nxt;
  logic fill_init_r, fill_init_nxt;
  logic rd_sel_r, rd_sel_nxt;
  logic out_valid_r, out_valid_nxt;

  logic [tcw_pkg::BYTE_W-1:0] ch_r, attr_r;
  logic [tcw_pkg::FLD_W-1:0]  out_cur_r;
  logic [tcw_pkg::BYTE_W-1:0] out_ch_r, out_at_r;
  logic load_out;
  logic latch_put;

  logic                       ram_we, ram_re;
  logic [AW-1:0]              ram_waddr, ram_raddr;
  logic [tcw_pkg::CELL_W-1:0] ram_wdata, ram_rdata;

  logic           accept, out_free;
  logic [CW1-1:0] nl_pos;
  logic [CW-1:0]  copy_src, copy_dst;
  logic [XW-1:0]  idx_x, nc_x, cur_x;
  logic [PW-1:0]  quo_prod;
  logic [CW-1:0]  row_q, row_base;

  // screen store
  tcw_ram #(
    .WIDTH (tcw_pkg::CELL_W),
    .DEPTH (CELLS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // handshake
  assign in_if.ready = (state_r == tcw_pkg::S_IDLE);
  assign accept      = in_if.valid & in_if.ready;
  assign out_free    = ~out_valid_r | out_if.ready;

  // address arithmetic
  assign nl_pos   = {1'b0, cur_r} - CW1'(col_r) + COLS_W;
  assign copy_src = ptr_r + COLS_C;
  assign copy_dst = ptr_r - CW'(1);
  assign idx_x    = XW'(in_if.cell_index);
  assign nc_x     = XW'(in_if.cursor_load);
  assign cur_x    = XW'(cur_r);

  // row of the cursor by reciprocal multiply, then start of that row
  assign quo_prod = PW'(cur_r) * PW'(RECIP_C);
  assign row_q    = quo_prod[DIV_S +: CW];
  assign row_base = row_q * COLS_C;

  // sequencer
  always_comb begin
    state_nxt       = state_r;
    cur_nxt         = cur_r;
    col_nxt         = col_r;
    ptr_nxt         = ptr_r;
    fill_attr_nxt   = fill_attr_r;
    fill_scroll_nxt = fill_scroll_r;
    fill_init_nxt   = fill_init_r;
    rd_sel_nxt      = rd_sel_r;
    ram_we          = 1'b0;
    ram_waddr       = cur_r[AW-1:0];
    ram_wdata       = {in_if.attr, in_if.ch};
    ram_re          = 1'b0;
    ram_raddr       = idx_x[AW-1:0];
    load_out        = 1'b0;
    latch_put       = 1'b0;

    unique case (state_r)
      tcw_pkg::S_IDLE: begin
        if (accept) begin
          rd_sel_nxt = 1'b0;
          unique case (in_if.op)
            tcw_pkg::OP_PUT: begin
              if (in_if.ch == tcw_pkg::NEWLINE_CHAR) begin
                // start of next row, saturating just past the bottom
                cur_nxt   = (nl_pos > CELLS_W) ? CELLS_C : nl_pos[CW-1:0];
                col_nxt   = '0;
                state_nxt = tcw_pkg::S_FIN;
              end else if (cur_r >= CELLS_C) begin
                // past the bottom: scroll first
                latch_put     = 1'b1;
                ptr_nxt       = '0;
                fill_attr_nxt = blank_attr_r;
                state_nxt     = tcw_pkg::S_COPY;
              end else begin
                ram_we    = 1'b1;
                cur_nxt   = cur_r + CW'(1);
                col_nxt   = (col_r == LAST_COL_C) ? '0 : col_r + CLW'(1);
                state_nxt = tcw_pkg::S_FIN;
              end
            end
            tcw_pkg::OP_CLEAR: begin
              fill_attr_nxt   = blank_attr_r;
              fill_scroll_nxt = 1'b0;
              fill_init_nxt   = 1'b0;
              ptr_nxt         = '0;
              cur_nxt         = '0;
              col_nxt         = '0;
              state_nxt       = tcw_pkg::S_FILL;
            end
            tcw_pkg::OP_READ: begin
              ram_re     = 1'b1;
              rd_sel_nxt = (idx_x < CELLS_X);
              state_nxt  = tcw_pkg::S_FIN;
            end
            tcw_pkg::OP_SET: begin
              cur_nxt   = (nc_x > CELLS_X) ? CELLS_C : nc_x[CW-1:0];
              state_nxt = tcw_pkg::S_DIV;
            end
          endcase
        end
      end

      // column of a loaded cursor from its row start
      tcw_pkg::S_DIV: begin
        col_nxt   = CLW'(cur_r - row_base);
        state_nxt = tcw_pkg::S_FIN;
      end

      // blank sweep over a range of cells, ending at the last cell
      tcw_pkg::S_FILL: begin
        ram_we    = 1'b1;
        ram_waddr = ptr_r[AW-1:0];
        ram_wdata = {fill_attr_r, tcw_pkg::SPACE_CHAR};
        ptr_nxt   = ptr_r + CW'(1);
        if (ptr_r == LAST_CELL_C) begin
          if (fill_scroll_r) begin
            state_nxt = tcw_pkg::S_PUTW;
          end else if (fill_init_r) begin
            state_nxt = tcw_pkg::S_IDLE;
          end else begin
            state_nxt = tcw_pkg::S_FIN;
          end
        end
      end

      // move rows up: read one row ahead, write back in the following cycle
      tcw_pkg::S_COPY: begin
        ram_raddr = copy_src[AW-1:0];
        ram_waddr = copy_dst[AW-1:0];
        ram_wdata = ram_rdata;
        ram_re    = (ptr_r != LAST_ROW_C);
        ram_we    = (ptr_r != '0);
        if (ptr_r == LAST_ROW_C) begin
          fill_scroll_nxt = 1'b1;
          fill_init_nxt   = 1'b0;
          state_nxt       = tcw_pkg::S_FILL;
        end else begin
          ptr_nxt = ptr_r + CW'(1);
        end
      end

      // deferred put at the start of the last row
      tcw_pkg::S_PUTW: begin
        ram_we    = 1'b1;
        ram_waddr = LAST_ROW_C[AW-1:0];
        ram_wdata = {attr_r, ch_r};
        cur_nxt   = LAST_ROW_C + CW'(1);
        col_nxt   = CLW'(1);
        state_nxt = tcw_pkg::S_FIN;
      end

      // hand the result to the output register
      tcw_pkg::S_FIN: begin
        if (out_free) begin
          load_out  = 1'b1;
          state_nxt = tcw_pkg::S_IDLE;
        end
      end

      default: begin
        state_nxt = tcw_pkg::S_IDLE;
      end
    endcase
  end

  // output valid
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_if.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= tcw_pkg::S_FILL;
      cur_r         <= '0;
      col_r         <= '0;
      ptr_r         <= '0;
      blank_attr_r  <= tcw_pkg::RESET_ATTR;
      fill_attr_r   <= tcw_pkg::RESET_ATTR;
      fill_scroll_r <= 1'b0;
      fill_init_r   <= 1'b1;
      rd_sel_r      <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      cur_r         <= cur_nxt;
      col_r         <= col_nxt;
      ptr_r         <= ptr_nxt;
      fill_attr_r   <= fill_attr_nxt;
      fill_scroll_r <= fill_scroll_nxt;
      fill_init_r   <= fill_init_nxt;
      rd_sel_r      <= rd_sel_nxt;
      out_valid_r   <= out_valid_nxt;
      if (cfg_we) begin
        blank_attr_r <= cfg_wdata;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (latch_put) begin
      ch_r   <= in_if.ch;
      attr_r <= in_if.attr;
    end
    if (load_out) begin
      out_cur_r <= cur_x[tcw_pkg::FLD_W-1:0];
      out_ch_r  <= rd_sel_r ? ram_rdata[tcw_pkg::BYTE_W-1:0] : '0;
      out_at_r  <= rd_sel_r ? ram_rdata[tcw_pkg::CELL_W-1:tcw_pkg::BYTE_W] : '0;
    end
  end

  assign out_if.valid       = out_valid_r;
  assign out_if.cursor_cell = out_cur_r;
  assign out_if.read_char   = out_ch_r;
  assign out_if.read_attr   = out_at_r;

endmodule

`default_nettype wire

FILE: rtl/core/tcw_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module tcw_checker #(
  parameter int CELLS = 2000
) (
  input wire logic                       clk,
  input wire logic                       rst_n,
  input wire logic                       in_valid,
  input wire logic                       in_ready,
  input wire logic                       out_valid,
  input wire logic                       out_ready,
  input wire logic [tcw_pkg::FLD_W-1:0]  out_cursor_cell,
  input wire logic [tcw_pkg::BYTE_W-1:0] out_read_char,
  input wire logic [tcw_pkg::BYTE_W-1:0] out_read_attr
);

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_cursor_cell)
      && $stable(out_read_char) && $stable(out_read_attr))
    else $error("result beat changed while stalled");

  // cursor never beyond the cell just past the bottom
  a_cur_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_cursor_cell <= tcw_pkg::FLD_W'(CELLS))
    else $error("cursor out of range");

  // one command at a time
  a_one_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("command taken while another is in flight");

  // clearing pass after reset blocks commands and results
  a_reset_pass: assert property (@(posedge clk) disable iff (!rst_n)
    $past(!rst_n) |-> !in_ready && !out_valid)
    else $error("block active right after reset");

endmodule

bind text_console_writer_core tcw_checker #(
  .CELLS (COLS * ROWS)
) u_tcw_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_if.valid),
  .in_ready        (in_if.ready),
  .out_valid       (out_if.valid),
  .out_ready       (out_if.ready),
  .out_cursor_cell (out_if.cursor_cell),
  .out_read_char   (out_if.read_char),
  .out_read_attr   (out_if.read_attr)
);

`default_nettype wire

FILE: test/text_console_writer_core_test.sv
`timescale 1ns / 1ps

module text_console_writer_core_test;

  localparam int COLS = 80;
  localparam int ROWS = 25;
  localparam int PHASES = 5;
  localparam int ITEMS_PER_PHASE = 200;
  localparam int HOLD_CYCLES = 400;
  localparam int BURST_ITEMS = 40;
  localparam int SETTLE_CYCLES = 10;

  // one command beat
  typedef struct packed {
    tcw_pkg::op_t                op;
    logic [tcw_pkg::BYTE_W-1:0]  ch;
    logic [tcw_pkg::BYTE_W-1:0]  attr;
    logic [tcw_pkg::FLD_W-1:0]   cell_index;
    logic [tcw_pkg::FLD_W-1:0]   cursor_load;
  } console_cmd_t;

  // one result beat
  typedef struct packed {
    logic [tcw_pkg::FLD_W-1:0]   cursor_cell;
    logic [tcw_pkg::BYTE_W-1:0]  read_char;
    logic [tcw_pkg::BYTE_W-1:0]  read_attr;
  } console_result_t;

  // mirror of the screen store and cursor, plus the results still owed
  class console_mirror #(int COLS = 80, int ROWS = 25);
    localparam int CELLS = COLS * ROWS;
    logic [tcw_pkg::CELL_W-1:0] cells [CELLS];
    int                         cursor;
    logic [tcw_pkg::BYTE_W-1:0] blank_attr;
    console_result_t            owed_results[$];

    function new();
      blank_attr = tcw_pkg::RESET_ATTR;
      fill_screen(tcw_pkg::RESET_ATTR);
      cursor = 0;
    endfunction

    function void fill_screen(logic [tcw_pkg::BYTE_W-1:0] a);
      foreach (cells[i]) cells[i] = {a, tcw_pkg::SPACE_CHAR};
    endfunction

    // rows move up one, last row blanked, cursor to start of last row
    function void scroll_up();
      for (int i = 0; i < CELLS - COLS; i++) cells[i] = cells[i + COLS];
      for (int i = CELLS - COLS; i < CELLS; i++) cells[i] = {blank_attr, tcw_pkg::SPACE_CHAR};
      cursor = CELLS - COLS;
    endfunction

    function void apply_command(console_cmd_t c);
      console_result_t r;
      int              row_start;
      r = '0;
      case (c.op)
        tcw_pkg::OP_PUT: begin
          if (c.ch == tcw_pkg::NEWLINE_CHAR) begin
            row_start = (cursor / COLS + 1) * COLS;
            cursor = (row_start > CELLS) ? CELLS : row_start;
          end else begin
            if (cursor >= CELLS) scroll_up();
            cells[cursor] = {c.attr, c.ch};
            cursor++;
          end
        end
        tcw_pkg::OP_CLEAR: begin
          fill_screen(blank_attr);
          cursor = 0;
        end
        tcw_pkg::OP_READ: begin
          if (c.cell_index < CELLS) begin
            r.read_char = cells[c.cell_index][tcw_pkg::BYTE_W-1:0];
            r.read_attr = cells[c.cell_index][tcw_pkg::CELL_W-1:tcw_pkg::BYTE_W];
          end
        end
        tcw_pkg::OP_SET: begin
          cursor = (c.cursor_load > CELLS) ? CELLS : int'(c.cursor_load);
        end
        default: ;
      endcase
      r.cursor_cell = tcw_pkg::FLD_W'(cursor);
      owed_results.push_back(r);
    endfunction

    // empty string when the beat matches the oldest owed result
    function string compare_result(console_result_t got);
      console_result_t want;
      if (owed_results.size() == 0)
        return $sformatf("result with none owed: cursor %0d char %02h attr %02h",
                         got.cursor_cell, got.read_char, got.read_attr);
      want = owed_results.pop_front();
      if (got.cursor_cell !== want.cursor_cell || got.read_char !== want.read_char ||
          got.read_attr !== want.read_attr)
        return $sformatf("cursor %0d exp %0d, char %02h exp %02h, attr %02h exp %02h",
                         got.cursor_cell, want.cursor_cell, got.read_char, want.read_char,
                         got.read_attr, want.read_attr);
      return "";
    endfunction
  endclass

  logic                       clk = 1'b0;
  logic                       rst_n;
  logic                       cfg_we;
  logic [tcw_pkg::BYTE_W-1:0] cfg_wdata;
  int                         errors = 0;
  bit                         hold_req = 1'b0;
  bit                         tight_send = 1'b0;
  bit                         tight_recv = 1'b0;
  console_mirror #(COLS, ROWS) mirror;

  tcw_in_if  in_if ();
  tcw_out_if out_if ();

  text_console_writer_core #(
    .COLS(COLS),
    .ROWS(ROWS)
  ) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_if    (in_if),
    .out_if   (out_if),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  always #4 clk = ~clk;

  task automatic report_mismatch(input string msg);
    $display("mismatch at %0t: %s", $time, msg);
    errors++;
  endtask

  // used fields as given, ignored fields random
  function automatic console_cmd_t build_cmd(tcw_pkg::op_t op, int ch, int attr, int pos);
    console_cmd_t c;
    c.op = op;
    c.ch = tcw_pkg::BYTE_W'($urandom);
    c.attr = tcw_pkg::BYTE_W'($urandom);
    c.cell_index = tcw_pkg::FLD_W'($urandom);
    c.cursor_load = tcw_pkg::FLD_W'($urandom);
    case (op)
      tcw_pkg::OP_PUT: begin
        c.ch = tcw_pkg::BYTE_W'(ch);
        c.attr = tcw_pkg::BYTE_W'(attr);
      end
      tcw_pkg::OP_READ: c.cell_index = tcw_pkg::FLD_W'(pos);
      tcw_pkg::OP_SET: c.cursor_load = tcw_pkg::FLD_W'(pos);
      default: ;
    endcase
    return c;
  endfunction

  // mostly text with newlines, reads near the cursor, jumps toward the bottom
  function automatic console_cmd_t random_cmd();
    int pick;
    int pos;
    int span;
    pick = $urandom_range(0, 99);
    pos = $urandom_range(0, 2047);
    if (pick < 60) begin
      return build_cmd(tcw_pkg::OP_PUT,
                       ($urandom_range(0, 7) == 0) ? int'(tcw_pkg::NEWLINE_CHAR) :
                       $urandom_range(0, 255), $urandom_range(0, 255), 0);
    end else if (pick < 82) begin
      if ($urandom_range(0, 1) == 1 && mirror.cursor > 0) begin
        span = (mirror.cursor < 2 * COLS) ? mirror.cursor : 2 * COLS;
        pos = mirror.cursor - $urandom_range(1, span);
      end
      return build_cmd(tcw_pkg::OP_READ, 0, 0, pos);
    end else if (pick < 97) begin
      if ($urandom_range(0, 1) == 1) pos = $urandom_range(1900, 2047);
      return build_cmd(tcw_pkg::OP_SET, 0, 0, pos);
    end
    return build_cmd(tcw_pkg::OP_CLEAR, 0, 0, 0);
  endfunction

  // offer one command beat after the gap and wait for it to be taken
  task automatic send_cmd(input console_cmd_t c, input int gap);
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_if.valid       <= 1'b1;
    in_if.op          <= c.op;
    in_if.ch          <= c.ch;
    in_if.attr        <= c.attr;
    in_if.cell_index  <= c.cell_index;
    in_if.cursor_load <= c.cursor_load;
    do @(posedge clk); while (in_if.ready !== 1'b1);
    mirror.apply_command(c);
  endtask

  // stop offering and wait for every owed result, then let the block settle
  task automatic wait_drained();
    in_if.valid <= 1'b0;
    while (mirror.owed_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_blank_attr(input logic [tcw_pkg::BYTE_W-1:0] a);
    wait_drained();
    cfg_we    <= 1'b1;
    cfg_wdata <= a;
    @(posedge clk);
    cfg_we <= 1'b0;
    mirror.blank_attr = a;
  endtask

  function automatic int draw_gap();
    return tight_send ? 0 : $urandom_range(0, 9);
  endfunction

  // result side: random stalls, long hold on request, check each beat
  initial begin
    int              stall;
    int              beats;
    console_result_t got;
    string           msg;
    beats = 0;
    out_if.ready <= 1'b0;
    @(posedge clk);
    forever begin
      if (hold_req) begin
        out_if.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end else begin
        stall = tight_recv ? 0 : $urandom_range(0, 9);
        if (stall > 0) begin
          out_if.ready <= 1'b0;
          repeat (stall) @(posedge clk);
        end
      end
      out_if.ready <= 1'b1;
      do @(posedge clk); while (out_if.valid !== 1'b1);
      got.cursor_cell = out_if.cursor_cell;
      got.read_char   = out_if.read_char;
      got.read_attr   = out_if.read_attr;
      msg = mirror.compare_result(got);
      if (msg != "") report_mismatch(msg);
      beats++;
      if (beats % 40 == 0) tight_recv = ($urandom_range(0, 3) == 0);
    end
  end

  // stimulus
  initial begin
    logic [tcw_pkg::BYTE_W-1:0] attr_set [PHASES];
    int                         burst_left;
    mirror = new();
    in_if.valid       <= 1'b0;
    in_if.op          <= tcw_pkg::OP_PUT;
    in_if.ch          <= '0;
    in_if.attr        <= '0;
    in_if.cell_index  <= '0;
    in_if.cursor_load <= '0;
    cfg_we            <= 1'b0;
    cfg_wdata         <= '0;
    rst_n             <= 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // directed: byte extremes, newline, reads in and out of range
    send_cmd(build_cmd(tcw_pkg::OP_PUT, 'h41, 'h00, 0), draw_gap());
    send_cmd(build_cmd(tcw_pkg::OP_PUT, 'hFF, 'hFF, 0), draw_gap());
    send_cmd(build_cmd(tcw_pkg::OP_PUT, 'h00, 'h80, 0), draw_gap());
    send_cmd(build_cmd(tcw_pkg::OP_PUT, tcw_pkg::NEWLINE_CHAR, 'h55, 0), draw_gap());
    send_cmd(build_cmd(tcw_pkg::OP_READ, 0, 0, 0), draw_gap());
    send_cmd(build_cmd(tcw_pkg::OP_READ, 0, 0, 1), draw_gap());
    send_cmd(build_cmd(tcw_pkg::OP_READ, 0, 0, 80), draw_gap());
    send_cmd(build_cmd(tcw_pkg::OP_READ, 0, 0, 1999), draw_gap());
    send_cmd(build_cmd(tcw_pkg::OP_READ, 0, 0, 2000), draw_gap());
    send_cmd(build_cmd(tcw_pkg::OP_READ, 0, 0, 2047), draw_gap());
    // bottom of screen: newline saturation and scroll on put
    send_cmd(build_cmd(tcw_pkg::OP_SET, 0, 0, 1919), draw_gap());
    send_cmd(build_cmd(tcw_pkg::OP_PUT, 'h42, 'h1E, 0), draw_gap());
    send_cmd(build_cmd(tcw_pkg::OP_PUT, tcw_pkg::NEWLINE_CHAR, 'h00, 0), draw_gap());
    send_cmd(build_cmd(tcw_pkg::OP_PUT, tcw_pkg::NEWLINE_CHAR, 'hFF, 0), draw_gap());
    send_cmd(build_cmd(tcw_pkg::OP_PUT, 'h43, 'h2D, 0), draw_gap());
    send_cmd(build_cmd(tcw_pkg::OP_READ, 0, 0, 1840), draw_gap());
    send_cmd(build_cmd(tcw_pkg::OP_READ, 0, 0, 1920), draw_gap());
    send_cmd(build_cmd(tcw_pkg::OP_READ, 0, 0, 1921), draw_gap());
    // set cursor above the last cell saturates
    send_cmd(build_cmd(tcw_pkg::OP_SET, 0, 0, 2047), draw_gap());
    send_cmd(build_cmd(tcw_pkg::OP_PUT, 'h44, 'h07, 0), draw_gap());
    send_cmd(build_cmd(tcw_pkg::OP_SET, 0, 0, 0), draw_gap());
    send_cmd(build_cmd(tcw_pkg::OP_READ, 0, 0, 1840), draw_gap());
    send_cmd(build_cmd(tcw_pkg::OP_CLEAR, 0, 0, 0), draw_gap());
    send_cmd(build_cmd(tcw_pkg::OP_READ, 0, 0, 1), draw_gap());
    send_cmd(build_cmd(tcw_pkg::OP_SET, 0, 0, 1999), draw_gap());
    send_cmd(build_cmd(tcw_pkg::OP_PUT, 'h45, 'h99, 0), draw_gap());

    // random phases, blank attribute changed between them
    attr_set[0] = 8'h00;
    attr_set[1] = 8'hFF;
    attr_set[2] = tcw_pkg::BYTE_W'($urandom);
    attr_set[3] = tcw_pkg::BYTE_W'($urandom);
    attr_set[4] = tcw_pkg::RESET_ATTR;
    burst_left = 0;
    for (int phase = 0; phase < PHASES; phase++) begin
      write_blank_attr(attr_set[phase]);
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        if (n % 64 == 0) tight_send = ($urandom_range(0, 3) == 0);
        // result side holds off while commands keep coming back to back
        if (phase == 0 && n == 20) begin
          hold_req = 1'b1;
          burst_left = BURST_ITEMS;
        end
        // let everything owed come back before going on
        if (phase == 2 && n == 100) wait_drained();
        if (burst_left > 0) begin
          burst_left--;
          send_cmd(random_cmd(), 0);
        end else begin
          send_cmd(random_cmd(), draw_gap());
        end
      end
    end

    wait_drained();
    if (errors == 0) begin
      $display("text_console_writer_core_test passed");
    end else begin
      $display("text_console_writer_core_test failed");
    end
    $finish;
  end

  // run limit
  initial begin
    #60_000_000;
    $display("text_console_writer_core_test failed");
    $finish;
  end

endmodule
